/* hdl/srdz_pkg.sv */
package srdz_pkg;

  localparam int RAW_W  = 16;
  localparam int DZ_W   = 15;
  localparam int SQ_W   = 32;
  localparam int RAD_W  = 48;
  localparam int ROOT_W = 24;
  localparam int REM_W  = 27;
  localparam int NUM_W  = 39;
  localparam int Q_W    = 15;

  localparam logic [DZ_W-1:0] FULL_SCALE = 15'h7fff;
  localparam logic [DZ_W-1:0] DZ_MAX     = 15'd32766;
  localparam logic [DZ_W-1:0] DZ_RESET   = 15'd7849;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
  } in_word_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] out_x;
    logic signed [RAW_W-1:0] out_y;
    logic [DZ_W-1:0]         out_len;
  } out_word_t;

endpackage

/* hdl/stick_radial_dead_zone.sv */
// Scaled radial dead zone for one thumbstick sample. A word is taken at every
// clock edge where start is high; busy stays low, so a new word may follow in
// every cycle. The result appears on out_word for one cycle with out_valid high;
// the receiver cannot stall it, so it must take every result as it comes. The
// pipe holds a chain of 24 square-root cells (one root bit each) and two divider
// chains of 15 cells (one quotient bit each): one for the rescaled length and
// one, in two parallel lanes, for the x and y components. Samples inside the
// dead zone, and the centered stick with a zero dead zone, come out as all
// zeros. cfg_wdata is written to the dead-zone radius when cfg_we is high;
// 32767 is stored as 32766. Write it only while no sample is in flight.
module stick_radial_dead_zone (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  srdz_pkg::in_word_t         in_word,
  input  logic                       cfg_we,
  input  logic [srdz_pkg::DZ_W-1:0]  cfg_wdata,
  output logic                       out_valid,
  output srdz_pkg::out_word_t        out_word
);
  import srdz_pkg::*;

  localparam int SQ_N  = ROOT_W;
  localparam int DIV_N = Q_W;
  localparam int ST_W  = 2*RAW_W + DZ_W + 1;
  localparam int LT_W  = 2 + 2*RAW_W + ROOT_W + 1 + 1;
  localparam int AT_W  = 1 + DZ_W + 1;

  // dead-zone register
  logic [DZ_W-1:0] dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= DZ_RESET;
    end else if (cfg_we) begin
      dz_r <= (cfg_wdata > DZ_MAX) ? DZ_MAX : cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // stage 1: capture the sample and the radius
  logic              s1_valid_r;
  logic [RAW_W-1:0]  s1_x_r, s1_y_r;
  logic [DZ_W-1:0]   s1_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r  <= in_word.raw_x;
    s1_y_r  <= in_word.raw_y;
    s1_dz_r <= dz_r;
  end

  // stage 2: squares
  logic              s2_valid_r;
  logic [SQ_W-1:0]   s2_sq_r;
  logic [2*DZ_W-1:0] s2_dzsq_r;
  logic [RAW_W-1:0]  s2_x_r, s2_y_r;
  logic [DZ_W-1:0]   s2_dz_r;
  logic signed [SQ_W-1:0] xx, yy;

  assign xx = $signed(s1_x_r) * $signed(s1_x_r);
  assign yy = $signed(s1_y_r) * $signed(s1_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_sq_r   <= $unsigned(xx) + $unsigned(yy);
    s2_dzsq_r <= s1_dz_r * s1_dz_r;
    s2_x_r    <= s1_x_r;
    s2_y_r    <= s1_y_r;
    s2_dz_r   <= s1_dz_r;
  end

  // square-root chain on sq << 16, tag carries x, y, radius and the inside flag
  logic              sq_v   [0:SQ_N];
  logic [RAD_W-1:0]  sq_rad [0:SQ_N];
  logic [REM_W-1:0]  sq_rem [0:SQ_N];
  logic [ROOT_W-1:0] sq_root[0:SQ_N];
  logic [ST_W-1:0]   sq_tag [0:SQ_N];

  assign sq_v[0]    = s2_valid_r;
  assign sq_rad[0]  = {s2_sq_r, 16'h0000};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_tag[0]  = {s2_x_r, s2_y_r, s2_dz_r, (s2_sq_r < {2'b00, s2_dzsq_r})};

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    srdz_sqrt_cell #(.TAG_W(ST_W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[i]),
      .in_rad    (sq_rad[i]),
      .in_rem    (sq_rem[i]),
      .in_root   (sq_root[i]),
      .in_tag    (sq_tag[i]),
      .out_valid (sq_v[i+1]),
      .out_rad   (sq_rad[i+1]),
      .out_rem   (sq_rem[i+1]),
      .out_root  (sq_root[i+1]),
      .out_tag   (sq_tag[i+1])
    );
  end

  // stage: form numerator and divisor of the length, split signs
  logic [ROOT_W-1:0] mag;
  logic [RAW_W-1:0]  m_x, m_y;
  logic [DZ_W-1:0]   m_dz;
  logic              m_in;
  logic [ROOT_W-1:0] diff;

  assign mag = sq_root[SQ_N];
  assign {m_x, m_y, m_dz, m_in} = sq_tag[SQ_N];
  assign diff = mag - {1'b0, m_dz, 8'h00};

  logic              n_valid_r;
  logic [NUM_W-1:0]  n_num_r;
  logic [DZ_W+7:0]   n_den_r;
  logic [LT_W-1:0]   n_tag_r;
  logic [RAW_W-1:0]  ux, uy;

  assign ux = m_x[RAW_W-1] ? (~m_x + 1'b1) : m_x;
  assign uy = m_y[RAW_W-1] ? (~m_y + 1'b1) : m_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_valid_r <= 1'b0;
    end else begin
      n_valid_r <= sq_v[SQ_N];
    end
  end

  // diff * 32767 as a shift and subtract
  always_ff @(posedge clk) begin
    n_num_r <= {diff, 15'h0000} - {15'h0000, diff};
    n_den_r <= {FULL_SCALE - m_dz, 8'h00};
    n_tag_r <= {m_x[RAW_W-1], ux, m_y[RAW_W-1], uy, mag, (m_in || (mag == '0)), 1'b0};
  end

  // length divider chain; saturation is decided up front
  logic             sat;
  logic             ld_v  [0:DIV_N];
  logic [NUM_W-1:0] ld_rem[0:DIV_N];
  logic [NUM_W-1:0] ld_dsh[0:DIV_N];
  logic [Q_W-1:0]   ld_q  [0:DIV_N];
  logic [LT_W-1:0]  ld_tag[0:DIV_N];

  assign sat       = {1'b0, n_num_r} >= {n_den_r, 15'h0000};
  assign ld_v[0]   = n_valid_r;
  assign ld_rem[0] = n_num_r;
  assign ld_dsh[0] = {2'b00, n_den_r, 14'h0000};
  assign ld_q[0]   = '0;
  assign ld_tag[0] = {n_tag_r[LT_W-1:1], sat};

  for (genvar i = 0; i < DIV_N; i++) begin : g_len
    srdz_div_cell #(.TAG_W(LT_W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ld_v[i]),
      .in_rem    (ld_rem[i]),
      .in_dsh    (ld_dsh[i]),
      .in_q      (ld_q[i]),
      .in_tag    (ld_tag[i]),
      .out_valid (ld_v[i+1]),
      .out_rem   (ld_rem[i+1]),
      .out_dsh   (ld_dsh[i+1]),
      .out_q     (ld_q[i+1]),
      .out_tag   (ld_tag[i+1])
    );
  end

  logic              l_sx, l_sy, l_zero, l_sat;
  logic [RAW_W-1:0]  l_ux, l_uy;
  logic [ROOT_W-1:0] l_mag;

  assign {l_sx, l_ux, l_sy, l_uy, l_mag, l_zero, l_sat} = ld_tag[DIV_N];

  // stage: clamp the length
  logic              p_valid_r;
  logic [DZ_W-1:0]   p_len_r;
  logic              p_sx_r, p_sy_r, p_zero_r;
  logic [RAW_W-1:0]  p_ux_r, p_uy_r;
  logic [ROOT_W-1:0] p_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= ld_v[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    p_len_r  <= l_sat ? FULL_SCALE : ld_q[DIV_N];
    p_sx_r   <= l_sx;
    p_sy_r   <= l_sy;
    p_zero_r <= l_zero;
    p_ux_r   <= l_ux;
    p_uy_r   <= l_uy;
    p_mag_r  <= l_mag;
  end

  // stage: |axis| * len
  logic                    m2_valid_r;
  logic [RAW_W+DZ_W-1:0]   m2_px_r, m2_py_r;
  logic [DZ_W-1:0]         m2_len_r;
  logic                    m2_sx_r, m2_sy_r, m2_zero_r;
  logic [ROOT_W-1:0]       m2_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_valid_r <= 1'b0;
    end else begin
      m2_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    m2_px_r   <= p_ux_r * p_len_r;
    m2_py_r   <= p_uy_r * p_len_r;
    m2_len_r  <= p_len_r;
    m2_sx_r   <= p_sx_r;
    m2_sy_r   <= p_sy_r;
    m2_zero_r <= p_zero_r;
    m2_mag_r  <= p_mag_r;
  end

  // axis divider lanes: (|a| * len << 8) / mag, quotient never exceeds len
  logic             ax_v  [0:DIV_N];
  logic [NUM_W-1:0] ax_rem[0:DIV_N];
  logic [NUM_W-1:0] ax_dsh[0:DIV_N];
  logic [Q_W-1:0]   ax_q  [0:DIV_N];
  logic [AT_W-1:0]  ax_tag[0:DIV_N];
  logic             ay_v  [0:DIV_N];
  logic [NUM_W-1:0] ay_rem[0:DIV_N];
  logic [NUM_W-1:0] ay_dsh[0:DIV_N];
  logic [Q_W-1:0]   ay_q  [0:DIV_N];
  logic             ay_tag[0:DIV_N];

  assign ax_v[0]   = m2_valid_r;
  assign ax_rem[0] = {m2_px_r, 8'h00};
  assign ax_dsh[0] = {1'b0, m2_mag_r, 14'h0000};
  assign ax_q[0]   = '0;
  assign ax_tag[0] = {m2_sx_r, m2_len_r, m2_zero_r};
  assign ay_v[0]   = m2_valid_r;
  assign ay_rem[0] = {m2_py_r, 8'h00};
  assign ay_dsh[0] = {1'b0, m2_mag_r, 14'h0000};
  assign ay_q[0]   = '0;
  assign ay_tag[0] = m2_sy_r;

  for (genvar i = 0; i < DIV_N; i++) begin : g_axis
    srdz_div_cell #(.TAG_W(AT_W)) u_xcell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ax_v[i]),
      .in_rem    (ax_rem[i]),
      .in_dsh    (ax_dsh[i]),
      .in_q      (ax_q[i]),
      .in_tag    (ax_tag[i]),
      .out_valid (ax_v[i+1]),
      .out_rem   (ax_rem[i+1]),
      .out_dsh   (ax_dsh[i+1]),
      .out_q     (ax_q[i+1]),
      .out_tag   (ax_tag[i+1])
    );
    srdz_div_cell #(.TAG_W(1)) u_ycell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ay_v[i]),
      .in_rem    (ay_rem[i]),
      .in_dsh    (ay_dsh[i]),
      .in_q      (ay_q[i]),
      .in_tag    (ay_tag[i]),
      .out_valid (ay_v[i+1]),
      .out_rem   (ay_rem[i+1]),
      .out_dsh   (ay_dsh[i+1]),
      .out_q     (ay_q[i+1]),
      .out_tag   (ay_tag[i+1])
    );
  end

  // output stage: restore signs, drop everything inside the dead zone
  logic             f_sx, f_sy, f_zero;
  logic [DZ_W-1:0]  f_len;
  logic [RAW_W-1:0] qx, qy;
  logic             out_valid_r;
  out_word_t        out_word_r;

  assign {f_sx, f_len, f_zero} = ax_tag[DIV_N];
  assign f_sy = ay_tag[DIV_N];
  assign qx = {1'b0, ax_q[DIV_N]};
  assign qy = {1'b0, ay_q[DIV_N]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ax_v[DIV_N] && ay_v[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (f_zero) begin
      out_word_r <= '0;
    end else begin
      out_word_r.out_x   <= f_sx ? (~qx + 1'b1) : qx;
      out_word_r.out_y   <= f_sy ? (~qy + 1'b1) : qy;
      out_word_r.out_len <= f_len;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* hdl/srdz_sqrt_cell.sv */
module srdz_sqrt_cell #(
  parameter int TAG_W = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [srdz_pkg::RAD_W-1:0]     in_rad,
  input  logic [srdz_pkg::REM_W-1:0]     in_rem,
  input  logic [srdz_pkg::ROOT_W-1:0]    in_root,
  input  logic [TAG_W-1:0]               in_tag,
  output logic                           out_valid,
  output logic [srdz_pkg::RAD_W-1:0]     out_rad,
  output logic [srdz_pkg::REM_W-1:0]     out_rem,
  output logic [srdz_pkg::ROOT_W-1:0]    out_root,
  output logic [TAG_W-1:0]               out_tag
);
  import srdz_pkg::*;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;
  logic             valid_r;
  logic [RAD_W-1:0] rad_r;
  logic [REM_W-1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [TAG_W-1:0] tag_r;

  // one root digit: bring down two radicand bits, try (root << 2) | 1
  always_comb begin
    rem_sh = {in_rem[REM_W-3:0], in_rad[RAD_W-1 -: 2]};
    trial  = {1'b0, in_root, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= {in_rad[RAD_W-3:0], 2'b00};
    rem_r  <= ge ? rem_sh - trial : rem_sh;
    root_r <= {in_root[ROOT_W-2:0], ge};
    tag_r  <= in_tag;
  end

  assign out_valid = valid_r;
  assign out_rad   = rad_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_tag   = tag_r;

endmodule

/* hdl/srdz_div_cell.sv */
module srdz_div_cell #(
  parameter int TAG_W = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [srdz_pkg::NUM_W-1:0]   in_rem,
  input  logic [srdz_pkg::NUM_W-1:0]   in_dsh,
  input  logic [srdz_pkg::Q_W-1:0]     in_q,
  input  logic [TAG_W-1:0]             in_tag,
  output logic                         out_valid,
  output logic [srdz_pkg::NUM_W-1:0]   out_rem,
  output logic [srdz_pkg::NUM_W-1:0]   out_dsh,
  output logic [srdz_pkg::Q_W-1:0]     out_q,
  output logic [TAG_W-1:0]             out_tag
);
  import srdz_pkg::*;

  logic             ge;
  logic             valid_r;
  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] dsh_r;
  logic [Q_W-1:0]   q_r;
  logic [TAG_W-1:0] tag_r;

  assign ge = in_rem >= in_dsh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // one quotient bit: subtract the shifted divisor if it fits, then halve it
  always_ff @(posedge clk) begin
    rem_r <= ge ? in_rem - in_dsh : in_rem;
    dsh_r <= {1'b0, in_dsh[NUM_W-1:1]};
    q_r   <= {in_q[Q_W-2:0], ge};
    tag_r <= in_tag;
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_dsh   = dsh_r;
  assign out_q     = q_r;
  assign out_tag   = tag_r;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import srdz_pkg::*;

  // Cycles from an accepted word to its result; the drain below adds margin.
  localparam int PIPE_DEPTH = 60;
  localparam int DRAIN_CYCLES = PIPE_DEPTH + 16;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word = '0;
  logic cfg_we = 1'b0;
  logic [DZ_W-1:0] cfg_wdata = '0;
  logic out_valid;
  out_word_t out_word;

  stick_radial_dead_zone DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_word(out_word)
  );

  always #10 clk = ~clk;

  // Shadow of the dead-zone register and the queue of pending results.
  logic [DZ_W-1:0] zone_radius = DZ_RESET;
  out_word_t pending_words[$];
  int fails = 0;
  int stall_count = 0;
  bit burst_mode = 1'b0;

  // Floor square root, one result bit per pass.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scale the part of one axis along the direction of the stick.
  function automatic logic [RAW_W-1:0] axis_share(longint a, longint unsigned len_v,
                                                  longint unsigned mag);
    longint unsigned ua;
    logic [RAW_W-1:0] q;
    ua = (a < 0) ? longint'(-a) : a;
    q = 16'((ua * 256 * len_v) / mag);
    return (a < 0) ? -q : q;
  endfunction

  // Predict the normalized stick word for one sample at the given radius.
  function automatic out_word_t radial_scale(logic signed [RAW_W-1:0] x,
                                             logic signed [RAW_W-1:0] y,
                                             logic [DZ_W-1:0] dz);
    longint sx;
    longint sy;
    longint unsigned dzl;
    longint unsigned sq;
    longint unsigned mag;
    longint unsigned len_v;
    out_word_t r;
    r = '0;
    sx = x;
    sy = y;
    dzl = dz;
    sq = longint'(sx * sx) + longint'(sy * sy);
    if (sq < dzl * dzl) return r;
    mag = floor_root(sq << 16);
    if (mag == 0) return r;
    len_v = ((mag - dzl * 256) * 32767) / ((32767 - dzl) * 256);
    if (len_v > 32767) len_v = 32767;
    r.out_x = axis_share(sx, len_v, mag);
    r.out_y = axis_share(sy, len_v, mag);
    r.out_len = len_v[DZ_W-1:0];
    return r;
  endfunction

  // Drive one word, after a random gap unless in burst mode; hold start high across back-to-back words.
  task automatic send_sample(logic signed [RAW_W-1:0] x, logic signed [RAW_W-1:0] y,
                             bit typed, out_word_t typed_word);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= '{raw_x: x, raw_y: y};
    do @(posedge clk); while (busy);
    pending_words.push_back(typed ? typed_word : radial_scale(x, y, zone_radius));
  endtask

  // Write the radius once the pipe has drained.
  task automatic set_radius(logic [DZ_W-1:0] v);
    start <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    zone_radius = (v > DZ_MAX) ? DZ_MAX : v;
  endtask

  // Draw a sample: full random, near the radius edge, or at the rails.
  task automatic random_sample();
    logic signed [RAW_W-1:0] x;
    logic signed [RAW_W-1:0] y;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      x = 16'($urandom);
      y = 16'($urandom);
    end else if (pick < 8) begin
      x = 16'(zone_radius + $urandom_range(0, 4) - 2);
      y = 16'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) x = -x;
      if ($urandom_range(0, 1)) y = -y;
      if ($urandom_range(0, 1)) {x, y} = {y, x};
    end else begin
      x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      y = $urandom_range(0, 1) ? 16'($urandom) : 16'sh0;
    end
    send_sample(x, y, 1'b0, '0);
  endtask

  // Directed table: radius writes and samples, typed results only where obvious.
  typedef struct {
    bit is_cfg;
    logic [DZ_W-1:0] dz;
    logic signed [RAW_W-1:0] x;
    logic signed [RAW_W-1:0] y;
    bit typed;
    out_word_t word;
  } stim_row_t;

  localparam out_word_t ZERO_WORD = '0;

  stim_row_t directed_rows[] = '{
    '{0, 0, 16'sd0, 16'sd0, 1, ZERO_WORD},
    '{0, 0, 16'sd7848, 16'sd0, 1, ZERO_WORD},
    '{0, 0, 16'sd0, -16'sd7848, 1, ZERO_WORD},
    '{0, 0, 16'sd32767, 16'sd0, 1, '{16'sd32767, 16'sd0, 15'd32767}},
    '{0, 0, -16'sd32768, 16'sd0, 1, '{-16'sd32767, 16'sd0, 15'd32767}},
    '{0, 0, 16'sd0, 16'sd32767, 1, '{16'sd0, 16'sd32767, 15'd32767}},
    '{0, 0, -16'sd32768, -16'sd32768, 0, ZERO_WORD},
    '{0, 0, 16'sd7849, 16'sd0, 0, ZERO_WORD},
    '{0, 0, 16'sd5550, 16'sd5550, 0, ZERO_WORD},
    '{0, 0, 16'sd32767, -16'sd32768, 0, ZERO_WORD},
    '{1, 15'd0, 16'sd0, 16'sd0, 0, ZERO_WORD},
    '{0, 0, 16'sd0, 16'sd0, 1, ZERO_WORD},
    '{0, 0, 16'sd1, 16'sd0, 0, ZERO_WORD},
    '{0, 0, -16'sd1, -16'sd1, 0, ZERO_WORD},
    '{0, 0, 16'sd32767, 16'sd32767, 0, ZERO_WORD},
    '{1, 15'd32767, 16'sd0, 16'sd0, 0, ZERO_WORD},
    '{0, 0, 16'sd32765, 16'sd0, 1, ZERO_WORD},
    '{0, 0, 16'sd32766, 16'sd0, 0, ZERO_WORD},
    '{0, 0, -16'sd32768, 16'sd0, 0, ZERO_WORD},
    '{1, 15'd1, 16'sd0, 16'sd0, 0, ZERO_WORD},
    '{0, 0, 16'sd1, 16'sd0, 0, ZERO_WORD},
    '{0, 0, 16'sd0, 16'sd1, 0, ZERO_WORD},
    '{0, 0, -16'sd32768, 16'sd32767, 0, ZERO_WORD}
  };

  // Check each result against the oldest pending word.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $error("result with nothing pending: %p", out_word);
        fails++;
      end else begin
        want = pending_words.pop_front();
        if (out_word.out_x !== want.out_x) begin
          $error("out_x expected %0d got %0d", want.out_x, out_word.out_x);
          fails++;
        end
        if (out_word.out_y !== want.out_y) begin
          $error("out_y expected %0d got %0d", want.out_y, out_word.out_y);
          fails++;
        end
        if (out_word.out_len !== want.out_len) begin
          $error("out_len expected %0d got %0d", want.out_len, out_word.out_len);
          fails++;
        end
      end
    end
  end

  // Watchdog: count cycles where no word moves in either direction.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  logic [DZ_W-1:0] radius_plan[] = '{15'd0, 15'd32767, 15'd100, 15'd20000, 15'd32766};

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        set_radius(directed_rows[i].dz);
      end else begin
        send_sample(directed_rows[i].x, directed_rows[i].y,
                    directed_rows[i].typed, directed_rows[i].word);
      end
    end

    // Random phases: back to reset value, then the planned radii and two random ones.
    set_radius(DZ_RESET);
    for (int n = 0; n < 630; n++) begin
      if (n % 90 == 89) begin
        if (n / 90 < radius_plan.size()) set_radius(radius_plan[n / 90]);
        else set_radius(15'($urandom_range(0, 32767)));
      end
      // Switch at random between stretches with and without gaps.
      if (n % 40 == 0) burst_mode = $urandom_range(0, 2) == 0;
      random_sample();
    end
    start <= 1'b0;

    wait (pending_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/srdz_pkg.sv
hdl/srdz_sqrt_cell.sv
hdl/srdz_div_cell.sv
hdl/stick_radial_dead_zone.sv
tb/testbench.sv
